// ----- design/slld_pkg.sv -----
`timescale 1ns / 1ps

package slld_pkg;

    // Counter width of the still and lost tick counters
    localparam int unsigned CounterWidth = 16;

    localparam int unsigned AxisWidth    = 16;
    localparam int unsigned MagWidth     = 16;
    localparam int unsigned SumWidth     = 2 * MagWidth;
    localparam int unsigned RemWidth     = MagWidth + 2;
    localparam int unsigned SecWidth     = 24;
    localparam int unsigned SptWidth     = 8;
    localparam int unsigned NeedWidth    = 8;
    localparam int unsigned ProdWidth    = CounterWidth + SptWidth;
    localparam int unsigned WideWidth    = (ProdWidth > SecWidth) ? ProdWidth : SecWidth;
    localparam int unsigned CfgDataWidth = 16;
    localparam int unsigned CfgIdxWidth  = 2;

    // One root digit per step
    localparam int unsigned RootSteps    = MagWidth;
    localparam int unsigned StepCntWidth = $clog2(RootSteps);

    localparam logic [CounterWidth-1:0] CntMax = {CounterWidth{1'b1}};
    localparam logic [WideWidth-1:0]    SecMax = WideWidth'({SecWidth{1'b1}});

    // Register map
    localparam logic [CfgIdxWidth-1:0] CFG_WINDOW_LOW         = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_WINDOW_HIGH        = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_STILL_TICKS_NEEDED = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_SECONDS_PER_TICK   = 2'd3;

    localparam logic [MagWidth-1:0]  WindowLowReset   = 16'd15000;
    localparam logic [MagWidth-1:0]  WindowHighReset  = 16'd18000;
    localparam logic [NeedWidth-1:0] TicksNeededReset = 8'd2;
    localparam logic [SptWidth-1:0]  SecPerTickReset  = 8'd10;

    // Item kinds
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_sel_t;

    localparam logic [StepCntWidth-1:0] LastAxisStep = StepCntWidth'(AXIS_Z);
    localparam logic [StepCntWidth-1:0] LastRootStep = StepCntWidth'(RootSteps - 1);

    typedef struct packed {
        logic      capture;
        logic      tick;
        logic      square;
        axis_sel_t axis;
        logic      root;
        logic      decide;
        logic      emit;
    } slld_cmd_t;

    typedef struct packed {
        logic out_free;
    } slld_status_t;

endpackage

// ----- design/slld_ctrl.sv -----
`timescale 1ns / 1ps

module slld_ctrl
    import slld_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_action,
    input  slld_status_t status,
    output slld_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [StepCntWidth-1:0] step_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    step_cnt_reg <= '0;
                    if (s_valid && s_action == ACT_SAMPLE) begin
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    if (step_cnt_reg == LastAxisStep) begin
                        step_cnt_reg <= '0;
                        state_reg    <= ST_ROOT;
                    end else begin
                        step_cnt_reg <= step_cnt_reg + 1'b1;
                    end
                end
                ST_ROOT: begin
                    if (step_cnt_reg == LastRootStep) begin
                        step_cnt_reg <= '0;
                        state_reg    <= ST_DECIDE;
                    end else begin
                        step_cnt_reg <= step_cnt_reg + 1'b1;
                    end
                end
                ST_DECIDE: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (status.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg    <= ST_IDLE;
                    step_cnt_reg <= '0;
                end
            endcase
        end
    end

    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        cmd.capture = s_valid && s_ready;
        cmd.tick    = cmd.capture && (s_action == ACT_TICK);
        cmd.square  = (state_reg == ST_SQUARE);
        cmd.axis    = axis_sel_t'(step_cnt_reg[1:0]);
        cmd.root    = (state_reg == ST_ROOT);
        cmd.decide  = (state_reg == ST_DECIDE);
        cmd.emit    = (state_reg == ST_EMIT) && status.out_free;
    end

endmodule

// ----- design/slld_dp.sv -----
`timescale 1ns / 1ps

module slld_dp
    import slld_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  slld_cmd_t                      cmd,
    output slld_status_t                   status,
    input  logic                           cfg_wr_en,
    input  logic [CfgIdxWidth-1:0]         cfg_index,
    input  logic [CfgDataWidth-1:0]        cfg_wdata,
    input  logic signed [AxisWidth-1:0]    s_accel_x,
    input  logic signed [AxisWidth-1:0]    s_accel_y,
    input  logic signed [AxisWidth-1:0]    s_accel_z,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [MagWidth-1:0]            m_magnitude,
    output logic                           m_lost,
    output logic                           m_report_valid,
    output logic [SecWidth-1:0]            m_seconds_lost
);

    // config
    logic [MagWidth-1:0]  window_low_reg;
    logic [MagWidth-1:0]  window_high_reg;
    logic [NeedWidth-1:0] ticks_needed_reg;
    logic [SptWidth-1:0]  sec_per_tick_reg;

    // sample working registers
    logic signed [AxisWidth-1:0] ax_reg, ay_reg, az_reg;
    logic [SumWidth-1:0]         acc_reg, acc_next;
    logic [RemWidth-1:0]         rem_reg, rem_next;
    logic [MagWidth-1:0]         root_reg, root_next;

    // detector state
    logic [CounterWidth-1:0] still_reg, still_next;
    logic [CounterWidth-1:0] lost_ticks_reg, lost_ticks_next;
    logic                    armed_reg, armed_next;
    logic                    lost_reg, lost_next;

    // decision results
    logic                    rep_reg, rep_next;
    logic [ProdWidth-1:0]    prod_reg, prod_next;

    // output register
    logic                    m_valid_reg;
    logic [MagWidth-1:0]     m_magnitude_reg;
    logic                    m_lost_reg;
    logic                    m_report_valid_reg;
    logic [SecWidth-1:0]     m_seconds_lost_reg;

    logic signed [AxisWidth-1:0]   axis_val;
    logic signed [2*AxisWidth-1:0] square;
    logic [RemWidth-1:0]           rem_shift;
    logic [RemWidth-1:0]           trial;
    logic                          trial_ok;
    logic [CounterWidth-1:0]       still_inc;
    logic                          motion;
    logic [WideWidth-1:0]          prod_wide;
    logic [SecWidth-1:0]           secs_sat;

    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_low_reg   <= WindowLowReset;
            window_high_reg  <= WindowHighReset;
            ticks_needed_reg <= TicksNeededReset;
            sec_per_tick_reg <= SecPerTickReset;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WINDOW_LOW:         window_low_reg   <= cfg_wdata[MagWidth-1:0];
                CFG_WINDOW_HIGH:        window_high_reg  <= cfg_wdata[MagWidth-1:0];
                CFG_STILL_TICKS_NEEDED: ticks_needed_reg <= cfg_wdata[NeedWidth-1:0];
                CFG_SECONDS_PER_TICK:   sec_per_tick_reg <= cfg_wdata[SptWidth-1:0];
                default: ;
            endcase
        end
    end

    // squaring, one axis a cycle
    always_comb begin
        case (cmd.axis)
            AXIS_X:  axis_val = ax_reg;
            AXIS_Y:  axis_val = ay_reg;
            AXIS_Z:  axis_val = az_reg;
            default: axis_val = '0;
        endcase
        square = axis_val * axis_val;
    end

    // restoring square root, one result bit per step
    always_comb begin
        rem_shift = {rem_reg[RemWidth-3:0], acc_reg[SumWidth-1 -: 2]};
        trial     = {root_reg, 2'b01};
        trial_ok  = (rem_shift >= trial);
    end

    always_comb begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (cmd.capture) begin
            acc_next  = '0;
            rem_next  = '0;
            root_next = '0;
        end else if (cmd.square) begin
            acc_next = acc_reg + SumWidth'($unsigned(square));
        end else if (cmd.root) begin
            acc_next  = {acc_reg[SumWidth-3:0], 2'b00};
            rem_next  = trial_ok ? (rem_shift - trial) : rem_shift;
            root_next = {root_reg[MagWidth-2:0], trial_ok};
        end
    end

    // tick and sample state update
    always_comb begin
        still_inc       = (still_reg == CntMax) ? still_reg : still_reg + 1'b1;
        motion          = (root_reg < window_low_reg) || (root_reg > window_high_reg);
        still_next      = still_reg;
        lost_ticks_next = lost_ticks_reg;
        armed_next      = armed_reg;
        lost_next       = lost_reg;
        rep_next        = rep_reg;
        prod_next       = prod_reg;

        if (cmd.tick) begin
            still_next = still_inc;
            if (still_inc >= CounterWidth'(ticks_needed_reg)) begin
                if (lost_ticks_reg != CntMax) begin
                    lost_ticks_next = lost_ticks_reg + 1'b1;
                end
                armed_next = 1'b1;
                lost_next  = 1'b1;
            end
        end else if (cmd.decide) begin
            rep_next  = 1'b0;
            prod_next = '0;
            if (motion) begin
                still_next = '0;
                lost_next  = 1'b0;
            end
            if (lost_reg && !motion) begin
                if (armed_reg) begin
                    rep_next   = 1'b1;
                    armed_next = 1'b0;
                    if (lost_ticks_reg != '0) begin
                        prod_next = ProdWidth'(lost_ticks_reg - 1'b1)
                                  * ProdWidth'(sec_per_tick_reg);
                    end
                end
            end else begin
                lost_ticks_next = '0;
                armed_next      = 1'b0;
            end
        end
    end

    always_comb begin
        prod_wide = WideWidth'(prod_reg);
        secs_sat  = (prod_wide > SecMax) ? SecMax[SecWidth-1:0] : prod_wide[SecWidth-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ax_reg <= s_accel_x;
            ay_reg <= s_accel_y;
            az_reg <= s_accel_z;
        end
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rep_reg  <= rep_next;
        prod_reg <= prod_next;
        if (cmd.emit) begin
            m_magnitude_reg    <= root_reg;
            m_lost_reg         <= lost_reg;
            m_report_valid_reg <= rep_reg;
            m_seconds_lost_reg <= secs_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            still_reg      <= '0;
            lost_ticks_reg <= '0;
            armed_reg      <= 1'b0;
            lost_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            still_reg      <= still_next;
            lost_ticks_reg <= lost_ticks_next;
            armed_reg      <= armed_next;
            lost_reg       <= lost_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_magnitude    = m_magnitude_reg;
    assign m_lost         = m_lost_reg;
    assign m_report_valid = m_report_valid_reg;
    assign m_seconds_lost = m_seconds_lost_reg;

endmodule

// ----- design/stillness_lost_detector.sv -----
`timescale 1ns / 1ps

// Stillness / lost-tag detector. Each input transaction is either an
// accelerometer sample (s_action = 0) or a timer tick (s_action = 1). A tick
// gives no output transaction. A sample gives exactly one output transaction:
// m_magnitude = isqrt(x*x + y*y + z*z), the lost flag after the sample, and,
// when the tag is lost with a report pending, m_report_valid with
// m_seconds_lost = (lost ticks - 1) * seconds_per_tick, saturated to 24 bits
// (zero when no report). One item is worked on at a time: an accepted sample
// is squared axis by axis on the single 16x16 multiplier, passes through the
// bit-per-step square root and a decision step, and is loaded into the output
// register once that register is no longer held by m_ready low; the next
// transaction is taken only after that load. A new transaction can be taken
// while the previous result waits. Registers (0 window_low, 1 window_high
// (inclusive stationary band), 2 still_ticks_needed, 3 seconds_per_tick) must
// be written through cfg_wr_en / cfg_index / cfg_wdata only while idle; the
// block does not enforce this.

module stillness_lost_detector
    import slld_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,

    // configuration write port
    input  logic                        cfg_wr_en,
    input  logic [CfgIdxWidth-1:0]      cfg_index,
    input  logic [CfgDataWidth-1:0]     cfg_wdata,

    // input transactions
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic signed [AxisWidth-1:0] s_accel_x,
    input  logic signed [AxisWidth-1:0] s_accel_y,
    input  logic signed [AxisWidth-1:0] s_accel_z,

    // result transactions
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [MagWidth-1:0]         m_magnitude,
    output logic                        m_lost,
    output logic                        m_report_valid,
    output logic [SecWidth-1:0]         m_seconds_lost
);

    slld_cmd_t    cmd;
    slld_status_t status;

    // sequencer: accept, square, root, decide, emit
    slld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, detector counters, config and output register
    slld_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_accel_x      (s_accel_x),
        .s_accel_y      (s_accel_y),
        .s_accel_z      (s_accel_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_magnitude    (m_magnitude),
        .m_lost         (m_lost),
        .m_report_valid (m_report_valid),
        .m_seconds_lost (m_seconds_lost)
    );

endmodule

// ----- design/slld_checker.sv -----
`timescale 1ns / 1ps

module slld_checker
    import slld_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic [MagWidth-1:0] m_magnitude,
    input logic                m_lost,
    input logic                m_report_valid,
    input logic [SecWidth-1:0] m_seconds_lost
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_magnitude)
                                && $stable(m_seconds_lost))
        else $error("result changed while stalled");

    // a report only comes with the lost flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_report_valid |-> m_lost)
        else $error("report without lost flag");

    // seconds only carried by a report
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_report_valid |-> m_seconds_lost == '0)
        else $error("seconds lost without report");

    // nothing offered straight after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind stillness_lost_detector slld_checker u_slld_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_magnitude    (m_magnitude),
    .m_lost         (m_lost),
    .m_report_valid (m_report_valid),
    .m_seconds_lost (m_seconds_lost)
);
